[design/ipcs_pkg.sv]
// Shared types and constants for the IP packet checksum engine.
package ipcs_pkg;

    localparam int PosWidth = 17;
    localparam int SumWidth = 17;
    localparam int OffWidth = 7;

    localparam logic [7:0] PROTO_IP   = 8'd0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_LEN  = 3'd1,
        ST_IPV6      = 3'd2,
        ST_BAD_PROTO = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    // Finished packet, waiting for the final fold
    typedef struct packed {
        logic [SumWidth-1:0] sum;
        logic [7:0]          proto;
        logic [15:0]         len;
        logic [OffWidth-1:0] offset;
        status_t             status;
    } pend_t;

    function automatic logic [SumWidth-1:0] fold17(input logic [SumWidth-1:0] s);
        return {1'b0, s[15:0]} + {16'd0, s[16]};
    endfunction

endpackage

[design/ipcs_fold.sv]
// Final pseudo-header add, end-around fold and inversion, with the result register.
module ipcs_fold (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ipcs_pkg::pend_t             in_pend,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_checksum,
    output logic [ipcs_pkg::OffWidth-1:0] m_checksum_offset,
    output logic [2:0]                  m_status
);
    import ipcs_pkg::*;

    logic                valid_reg;
    logic [15:0]         ck_reg, ck_next;
    logic [OffWidth-1:0] off_reg, off_next;
    logic [2:0]          status_reg;
    logic [17:0]         total;
    logic [16:0]         t1;
    logic [16:0]         t2;
    logic                pseudo;

    assign in_ready = !valid_reg || m_ready;

    // Ones-complement sum is order free, so protocol and length join in one add
    always_comb begin
        pseudo = (in_pend.proto == PROTO_TCP) || (in_pend.proto == PROTO_UDP);
        total  = {1'b0, in_pend.sum}
               + (pseudo ? {10'd0, in_pend.proto} : 18'd0)
               + (pseudo ? {2'd0, in_pend.len} : 18'd0);
        t1     = {1'b0, total[15:0]} + {15'd0, total[17:16]};
        t2     = {1'b0, t1[15:0]} + {16'd0, t1[16]};
        if (in_pend.status == ST_OK) begin
            ck_next  = ~t2[15:0];
            off_next = in_pend.offset;
        end else begin
            ck_next  = 16'd0;
            off_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ck_reg     <= ck_next;
            off_reg    <= off_next;
            status_reg <= in_pend.status;
        end
    end

    assign m_valid           = valid_reg;
    assign m_checksum        = ck_reg;
    assign m_checksum_offset = off_reg;
    assign m_status          = status_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && status_reg != ST_OK |-> ck_reg == 16'd0 && off_reg == '0)
        else $error("non-ok result carries a checksum");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted request lost in result stage");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> valid_reg && !m_ready)
        else $error("result stage stalls while empty");

endmodule

[design/ip_packet_checksum_engine.sv]
// IPv4 header / TCP / UDP / ICMP checksum engine, one packet byte per request.
// Usage:
//   Input channel (s_*): one packet byte per request, starting at IPv4 header
//   byte 0. s_first_byte marks a packet start and latches s_protocol_number
//   and s_segment_length; s_last_byte marks the final byte.
//   Result channel (m_*): one request per packet, carrying the inverted
//   ones-complement checksum, its byte offset and a status code.
//   Throughput: one byte per cycle while s_ready is high; the running sum register
//   takes one byte each cycle through at most two end-around adds.
//   Result path: after the last byte is accepted, its sum passes the packet-end
//   register, then the fold/result register, before m_valid rises.
//   Stalls: s_ready only drops while both result-side registers are full and
//   m_ready is low; a result waiting at m_* does not block further bytes.
//   Reset: aresetn (synchronous, active low) empties the result path and
//   clears position, sum, header length, latched protocol and length.
module ip_packet_checksum_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_segment_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum,
    output logic [6:0]  m_checksum_offset,
    output logic [2:0]  m_status
);
    import ipcs_pkg::*;

    localparam logic [PosWidth-1:0] PosMax = '1;

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [SumWidth-1:0] sum_reg, sum_next;
    logic [5:0]          hl_reg, hl_next;
    logic [7:0]          proto_reg, proto_next;
    logic [15:0]         len_reg, len_next;
    logic                v6_reg, v6_next;
    logic                pend_valid_reg;
    pend_t               pend_reg, pend_next;
    logic                fold_ready;
    logic                accept;

    logic [PosWidth-1:0] p;
    logic [SumWidth-1:0] base, s1, s2;
    logic [15:0]         wd;
    logic                supported;
    logic [OffWidth-1:0] off;
    logic                at_off;
    logic [PosWidth-1:0] seg_end;
    logic                add_pseudo, add_main;
    logic [17:0]         cnt, need;
    status_t             status;

    assign s_ready = !pend_valid_reg || fold_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        p          = s_first_byte ? '0 : pos_reg;
        base       = s_first_byte ? '0 : sum_reg;
        proto_next = s_first_byte ? s_protocol_number : proto_reg;
        len_next   = s_first_byte ? s_segment_length : len_reg;
        if (p == '0) begin
            v6_next = (s_data_byte[7:4] == 4'd6);
            hl_next = {s_data_byte[3:0], 2'b00};
        end else begin
            v6_next = v6_reg;
            hl_next = hl_reg;
        end

        supported = proto_next inside {PROTO_IP, PROTO_ICMP, PROTO_TCP, PROTO_UDP};
        case (proto_next)
            PROTO_IP:   off = 7'd10;
            PROTO_ICMP: off = {1'b0, hl_next} + 7'd2;
            PROTO_TCP:  off = {1'b0, hl_next} + 7'd16;
            PROTO_UDP:  off = {1'b0, hl_next} + 7'd6;
            default:    off = '0;
        endcase

        // header length is a multiple of four, so segment parity equals byte parity
        wd      = p[0] ? {8'd0, s_data_byte} : {s_data_byte, 8'd0};
        at_off  = (p == {10'd0, off}) || (p == {10'd0, off} + 17'd1);
        seg_end = {11'd0, hl_next} + {1'b0, len_next};

        add_pseudo = ((proto_next == PROTO_TCP) || (proto_next == PROTO_UDP))
                   && p >= 17'd12 && p < 17'd20;
        if (proto_next == PROTO_IP) begin
            add_main = (p < {11'd0, hl_next}) && !at_off;
        end else begin
            add_main = supported && (p >= {11'd0, hl_next}) && (p < seg_end) && !at_off;
        end

        s1 = add_pseudo ? fold17(base) + {1'b0, wd} : base;
        s2 = add_main   ? fold17(s1) + {1'b0, wd}   : s1;

        cnt = {1'b0, p} + 18'd1;
        if (proto_next == PROTO_IP) begin
            need = {12'd0, hl_next};
        end else begin
            need = {1'b0, seg_end};
            if (proto_next != PROTO_ICMP && need < 18'd20) begin
                need = 18'd20;
            end
        end

        if (len_next == 16'd0) begin
            status = ST_ZERO_LEN;
        end else if (v6_next) begin
            status = ST_IPV6;
        end else if (!supported) begin
            status = ST_BAD_PROTO;
        end else if (cnt < need) begin
            status = ST_TRUNC;
        end else begin
            status = ST_OK;
        end

        if (s_last_byte) begin
            pos_next = '0;
            sum_next = '0;
        end else begin
            pos_next = (p != PosMax) ? p + 17'd1 : p;
            sum_next = s2;
        end

        pend_next.sum    = s2;
        pend_next.proto  = proto_next;
        pend_next.len    = len_next;
        pend_next.offset = off;
        pend_next.status = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            hl_reg         <= '0;
            proto_reg      <= '0;
            len_reg        <= '0;
            v6_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                hl_reg    <= hl_next;
                proto_reg <= proto_next;
                len_reg   <= len_next;
                v6_reg    <= v6_next;
            end
            if (s_ready) begin
                pend_valid_reg <= accept && s_last_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            pend_reg <= pend_next;
        end
    end

    ipcs_fold u_fold (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (pend_valid_reg),
        .in_ready          (fold_ready),
        .in_pend           (pend_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_checksum        (m_checksum),
        .m_checksum_offset (m_checksum_offset),
        .m_status          (m_status)
    );

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> pos_reg == '0 && sum_reg == '0)
        else $error("packet state not cleared after last byte");
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= 17'h1FF00)
        else $error("running sum outside folded range");
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pend_valid_reg && m_valid && !m_ready)
        else $error("input stalled with room in the result path");

endmodule
